// File: hdl/feedback_delay_line_interp_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the feedback delay line core
// Shared property shapes; every use names clock and reset of its scope.
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_DELAY_LINE_INTERP_CORE_MACROS_SVH
`define FEEDBACK_DELAY_LINE_INTERP_CORE_MACROS_SVH

// same-cycle implication, off while reset is high
`define FDLI_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define FDLI_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// what must hold in the cycle after a reset cycle
`define FDLI_ASSERT_RST(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/fdli_pkg.sv
// ----------------------------------------------------------------------------
// fdli_pkg
// Types, constants and helpers shared by the feedback delay line modules.
// ----------------------------------------------------------------------------
package fdli_pkg;

   localparam int unsigned SAMPLE_W      = 24;
   localparam int unsigned DELAY_W       = 24;
   localparam int unsigned GAIN_W        = 16;
   localparam int unsigned CSR_IDX_W     = 2;
   localparam int unsigned ADDR_W_DEF    = 16;
   localparam int unsigned FRAC_BITS_DEF = 8;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WET      = 2'd2;

   localparam logic [GAIN_W-1:0] ONE_Q15 = 16'd32768;

   // floor(n/5) = (n * RECIP5) >> RECIP5_SHIFT, exact for n below 2^27
   localparam logic [27:0] RECIP5       = 28'd214748365;
   localparam int unsigned RECIP5_SHIFT = 30;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD0,
      ST_RD1,
      ST_INTERP,
      ST_MIX,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;    // latch input beat, compute read position
      logic rd_first;   // read word at floor-1, feedback product
      logic rd_second;  // read word at floor, keep first word
      logic interp;     // interpolation and reciprocal products
      logic mix;        // store write, pointer advance, wet/dry product
      logic load_out;   // load result register
   } dp_cmd_type;

   typedef struct packed {
      logic out_busy;   // result register holds a beat that is stalled
   } dp_status_type;

   function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
      return (g > ONE_Q15) ? ONE_Q15 : g;
   endfunction

   function automatic logic [SAMPLE_W-1:0] sat24(input logic signed [27:0] v);
      logic [SAMPLE_W-1:0] r;
      if (v > 28'sd8388607) begin
         r = 24'h7FFFFF;
      end else if (v < -28'sd8388608) begin
         r = 24'h800000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hdl/feedback_delay_line_interp_core.sv
// ----------------------------------------------------------------------------
// feedback_delay_line_interp_core
// Feedback delay with linear interpolation and wet/dry mix, Q1.23 audio.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample and its block end mark; a beat is taken when
//   req_valid is high and req_stall low. rsp_* returns one mixed sample per
//   beat taken, in order, with the block end mark copied.
//   csr_* writes delay (index 0, Q.FRAC_BITS), feedback (1) and wet (2);
//   write only while no sample is in flight.
// Timing:
//   The result register loads in ST_OUT, once the sequencer has walked a taken
//   beat through two reads of the single store port (ST_RD0, ST_RD1) and four
//   registered products; no new beat is taken until it is back in ST_IDLE.
//   A result waiting under rsp_stall does not block the next input beat;
//   that sample finishes and holds until the register frees up.
// Reset:
//   Settings, pointer and feedback history clear at once. The store is not
//   swept: a fill count marks unwritten words, which read as zero, so the
//   block takes input in the first cycle after reset.
module feedback_delay_line_interp_core #(
   parameter int unsigned ADDR_W    = fdli_pkg::ADDR_W_DEF,    // store depth 2^ADDR_W, 2..20
   parameter int unsigned FRAC_BITS = fdli_pkg::FRAC_BITS_DEF  // delay fraction, 1..16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [fdli_pkg::SAMPLE_W-1:0] req_audio_in,
   input  logic                                 req_block_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [fdli_pkg::SAMPLE_W-1:0] rsp_audio_out,
   output logic                                 rsp_block_end_out,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fdli_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fdli_pkg::DELAY_W-1:0]         csr_wdata
);
   import fdli_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   fdli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   fdli_dp #(
      .ADDR_W    (ADDR_W),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_audio_in      (req_audio_in),
      .req_block_end     (req_block_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_audio_out     (rsp_audio_out),
      .rsp_block_end_out (rsp_block_end_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

endmodule

// File: hdl/fdli_ctrl.sv
// ----------------------------------------------------------------------------
// fdli_ctrl
// Sequencer: steps one sample through reads, products and result load.
// ----------------------------------------------------------------------------
module fdli_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output fdli_pkg::dp_cmd_type   cmd,
   input  fdli_pkg::dp_status_type status
);
   import fdli_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_RD0;
         ST_RD0:    state_in = ST_RD1;
         ST_RD1:    state_in = ST_INTERP;
         ST_INTERP: state_in = ST_MIX;
         ST_MIX:    state_in = ST_OUT;
         ST_OUT:    if (!status.out_busy) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = reset;
            cmd.capture = req_valid && !reset;
         end
         ST_RD0:    cmd.rd_first  = 1'b1;
         ST_RD1:    cmd.rd_second = 1'b1;
         ST_INTERP: cmd.interp    = 1'b1;
         ST_MIX:    cmd.mix       = 1'b1;
         ST_OUT:    cmd.load_out  = !status.out_busy;
         default: begin
            cmd       = '0;
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// File: hdl/fdli_dp.sv
// ----------------------------------------------------------------------------
// fdli_dp
// Datapath: delay store, settings, pointer, products and result register.
// ----------------------------------------------------------------------------
module fdli_dp #(
   parameter int unsigned ADDR_W    = fdli_pkg::ADDR_W_DEF,
   parameter int unsigned FRAC_BITS = fdli_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  fdli_pkg::dp_cmd_type                   cmd,
   output fdli_pkg::dp_status_type                status,
   input  logic signed [fdli_pkg::SAMPLE_W-1:0]   req_audio_in,
   input  logic                                   req_block_end,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [fdli_pkg::SAMPLE_W-1:0]   rsp_audio_out,
   output logic                                   rsp_block_end_out,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [fdli_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [fdli_pkg::DELAY_W-1:0]           csr_wdata
);
   import fdli_pkg::*;

   localparam int unsigned DEPTH = 1 << ADDR_W;
   localparam int unsigned PW    = ADDR_W + FRAC_BITS;
   localparam int unsigned TW    = PW + DELAY_W;
   localparam int unsigned IPW   = FRAC_BITS + 26;
   localparam logic [IPW-1:0] HALF_LSB = IPW'(1) << (FRAC_BITS - 1);

   // settings
   logic [DELAY_W-1:0] cfg_delay_ff;
   logic [GAIN_W-1:0]  cfg_fb_ff;
   logic [GAIN_W-1:0]  cfg_wet_ff;

   // block state
   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [ADDR_W-1:0]   wp_ff;
   logic [ADDR_W:0]     fill_ff;   // words written since reset, saturates at DEPTH
   logic signed [SAMPLE_W-1:0] last_ff;

   // per-sample working registers
   logic signed [SAMPLE_W-1:0] x_ff;
   logic                       be_ff;
   logic [ADDR_W-1:0]          idx_ff;
   logic [FRAC_BITS-1:0]       frac_ff;
   logic [SAMPLE_W-1:0]        rdata_ff;
   logic                       rvalid_ff;
   logic signed [SAMPLE_W-1:0] y0_ff;
   logic signed [44:0]         fbp_ff;
   logic [26:0]                q_ff;
   logic [54:0]                rq_ff;
   logic signed [IPW-1:0]      ip_ff;
   logic signed [41:0]         mix_ff;

   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_audio_ff;
   logic                       rsp_be_ff;

   // combinational
   logic [TW-1:0]              pos_full;
   logic [ADDR_W-1:0]          rd_addr;
   logic                       rd_ok;
   logic [GAIN_W-1:0]          fb_c;
   logic [GAIN_W-1:0]          wet_c;
   logic [19:0]                fb19;
   logic signed [44:0]         fbp_in;
   logic signed [46:0]         fb_m;
   logic signed [28:0]         q_sum;
   logic signed [SAMPLE_W-1:0] y_rd;
   logic signed [24:0]         diff;
   logic signed [IPW-1:0]      ip_in;
   logic signed [IPW-1:0]      ip_rnd;
   logic signed [IPW-1:0]      ip_sh;
   logic signed [25:0]         dl_w;
   logic signed [SAMPLE_W-1:0] delayed;
   logic signed [24:0]         dx;
   logic signed [41:0]         mix_in;
   logic signed [25:0]         term;
   logic signed [27:0]         wsum;
   logic [SAMPLE_W-1:0]        wdata;
   logic signed [42:0]         acc;

   assign csr_ready       = !reset;
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_audio_out     = rsp_audio_ff;
   assign rsp_block_end_out = rsp_be_ff;

   // read position, wrapped modulo DEPTH << FRAC_BITS
   assign pos_full = {{DELAY_W{1'b0}}, wp_ff, {FRAC_BITS{1'b0}}}
                   - {{PW{1'b0}}, cfg_delay_ff};

   assign rd_addr = cmd.rd_second ? idx_ff : idx_ff - ADDR_W'(1);
   assign rd_ok   = ({1'b0, rd_addr} < fill_ff);

   // feedback: round(last * fb * 19 / (5 * 2^17))
   assign fb_c   = clamp_gain(cfg_fb_ff);
   assign fb19   = {fb_c, 4'b0} + {3'b0, fb_c, 1'b0} + {4'b0, fb_c};
   assign fbp_in = last_ff * $signed({1'b0, fb19});
   assign fb_m   = $signed({fbp_ff[44], fbp_ff, 1'b0}) + 47'sd655360;
   // offset keeps the dividend positive for the unsigned reciprocal
   assign q_sum  = $signed(fb_m[46:18]) + 29'sd83886080;
   assign term   = $signed({1'b0, rq_ff[54:RECIP5_SHIFT]}) - 26'sd16777216;
   assign wsum   = {{4{x_ff[23]}}, x_ff} + {{2{term[25]}}, term};
   assign wdata  = sat24(wsum);

   // interpolation: y0 + round((y1 - y0) * t / 2^F)
   assign y_rd    = rvalid_ff ? $signed(rdata_ff) : '0;
   assign diff    = {y_rd[23], y_rd} - {y0_ff[23], y0_ff};
   assign ip_in   = diff * $signed({1'b0, frac_ff});
   assign ip_rnd  = ip_ff + $signed(HALF_LSB);
   assign ip_sh   = ip_rnd >>> FRAC_BITS;
   assign dl_w    = {{2{y0_ff[23]}}, y0_ff} + ip_sh[25:0];
   assign delayed = dl_w[SAMPLE_W-1:0];

   // wet/dry: x + (d - x) * wet / 2^15, rounded
   assign wet_c  = clamp_gain(cfg_wet_ff);
   assign dx     = {delayed[23], delayed} - {x_ff[23], x_ff};
   assign mix_in = dx * $signed({1'b0, wet_c});
   assign acc    = $signed({{4{x_ff[23]}}, x_ff, 15'b0}) + $signed({mix_ff[41], mix_ff})
                 + 43'sd16384;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_delay_ff <= '0;
         cfg_fb_ff    <= '0;
         cfg_wet_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DELAY:    cfg_delay_ff <= csr_wdata;
            CSR_FEEDBACK: cfg_fb_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_WET:      cfg_wet_ff   <= csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
         last_ff <= '0;
      end else if (cmd.mix) begin
         wp_ff   <= wp_ff + ADDR_W'(1);
         last_ff <= delayed;
         if (!fill_ff[ADDR_W]) begin
            fill_ff <= fill_ff + (ADDR_W+1)'(1);
         end
      end
   end

   // single-port style store: reads and the write fall in different steps
   always_ff @(posedge clock) begin
      if (cmd.mix) begin
         mem[wp_ff] <= wdata;
      end
      if (cmd.rd_first || cmd.rd_second) begin
         rdata_ff  <= mem[rd_addr];
         rvalid_ff <= rd_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff    <= req_audio_in;
         be_ff   <= req_block_end;
         idx_ff  <= pos_full[PW-1:FRAC_BITS];
         frac_ff <= pos_full[FRAC_BITS-1:0];
      end
      if (cmd.rd_first) begin
         fbp_ff <= fbp_in;
      end
      if (cmd.rd_second) begin
         y0_ff <= y_rd;
         q_ff  <= q_sum[26:0];
      end
      if (cmd.interp) begin
         ip_ff <= ip_in;
         rq_ff <= q_ff * RECIP5;
      end
      if (cmd.mix) begin
         mix_ff <= mix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_audio_ff <= sat24(acc[42:15]);
         rsp_be_ff    <= be_ff;
      end
   end

endmodule

// File: hdl/fdli_checker.sv
// ----------------------------------------------------------------------------
// fdli_checker
// Port-level checks for the delay line core, bound to the top level.
// ----------------------------------------------------------------------------
`include "feedback_delay_line_interp_core_macros.svh"

module fdli_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [fdli_pkg::SAMPLE_W-1:0] rsp_audio_out,
   input logic                                 rsp_block_end_out
);
   import fdli_pkg::*;

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   // one sample in flight: input closes right after a beat
   `FDLI_ASSERT_NXT(a_one_in_flight, req_beat, req_stall, "beat taken while busy")

   // still busy when the result is due
   `FDLI_ASSERT_IMP(a_busy_to_out, req_beat ##5 1'b1, req_stall, "sequence ended early")

   // a stalled result holds
   `FDLI_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_audio_out) && $stable(rsp_block_end_out), "rsp changed")

   // no result left over after reset
   `FDLI_ASSERT_RST(a_rst_empty, !rsp_valid, "rsp valid after reset")

endmodule

bind feedback_delay_line_interp_core fdli_checker u_fdli_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_audio_out     (rsp_audio_out),
   .rsp_block_end_out (rsp_block_end_out)
);

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: feedback delay line with interpolation
// Drives samples and register writes into feedback_delay_line_interp_core,
// predicts every mixed output beat in a scoreboard that keeps its own copy
// of the delay memory, and checks the outputs in order under random gaps
// and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fdli_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned RANDOM_PHASES  = 8;
   localparam int unsigned PHASE_BEATS    = 104;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;  // no register behind it

   function automatic longint div_floor(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) begin
         q--;
      end
      return q;
   endfunction

   // nearest, ties toward +inf
   function automatic longint div_nearest(longint n, longint d);
      return div_floor(2 * n + d, 2 * d);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] clip24(longint v);
      if (v > 8388607) begin
         return 24'h7FFFFF;
      end else if (v < -8388608) begin
         return 24'h800000;
      end
      return v[SAMPLE_W-1:0];
   endfunction

   class echo_scoreboard;
      typedef struct {
         logic signed [SAMPLE_W-1:0] audio;
         logic                       blk_end;
      } mix_beat_type;

      logic signed [SAMPLE_W-1:0] line_mem [65536];
      bit [15:0]                  head;
      logic signed [SAMPLE_W-1:0] prev_tap;
      bit [DELAY_W-1:0]           delay_q8;
      bit [GAIN_W-1:0]            fb_reg;
      bit [GAIN_W-1:0]            wet_reg;
      mix_beat_type               mix_due[$];
      int                         n_errors;
      int                         n_checked;
      int                         n_rail;
      int                         n_marks;

      function new();
         foreach (line_mem[k]) begin
            line_mem[k] = '0;
         end
         head      = '0;
         prev_tap  = '0;
         delay_q8  = '0;
         fb_reg    = '0;
         wet_reg   = '0;
         n_errors  = 0;
         n_checked = 0;
         n_rail    = 0;
         n_marks   = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [DELAY_W-1:0] data);
         case (idx)
            CSR_DELAY:    delay_q8 = data;
            CSR_FEEDBACK: fb_reg = data[GAIN_W-1:0];
            CSR_WET:      wet_reg = data[GAIN_W-1:0];
            default:      ;
         endcase
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] x, logic be);
         bit [DELAY_W-1:0] pos;
         bit [15:0]        i0;
         bit [15:0]        i1;
         longint           xs, y0, y1, frac, tap, fb, wet, term, mixv;
         mix_beat_type     beat;
         // read point trails the write pointer; wraps over the whole span
         pos  = {head, 8'd0} - delay_q8;
         i1   = pos[23:8];
         i0   = i1 - 16'd1;
         frac = pos[7:0];
         y0   = line_mem[i0];
         y1   = line_mem[i1];
         xs   = x;
         tap  = clip24(div_nearest(y0 * (256 - frac) + y1 * frac, 256));
         fb   = (fb_reg > ONE_Q15) ? ONE_Q15 : fb_reg;
         // 0.95 * gain, exact
         term = div_nearest(longint'(prev_tap) * fb * 19, 20 * 32768);
         line_mem[head] = clip24(xs + term);
         prev_tap = tap[SAMPLE_W-1:0];
         wet  = (wet_reg > ONE_Q15) ? ONE_Q15 : wet_reg;
         mixv = div_nearest(xs * (32768 - wet) + tap * wet, 32768);
         if (mixv > 8388607 || mixv < -8388608) begin
            n_rail++;
         end
         if (be) begin
            n_marks++;
         end
         beat.audio   = clip24(mixv);
         beat.blk_end = be;
         mix_due.push_back(beat);
         head++;
      endfunction

      function void check_mix(logic signed [SAMPLE_W-1:0] audio, logic be);
         mix_beat_type want;
         if (mix_due.size() == 0) begin
            $display("%0t: output beat with nothing pending, audio_out=%0d block_end_out=%0b",
                     $time, audio, be);
            n_errors++;
            return;
         end
         want = mix_due.pop_front();
         n_checked++;
         if (audio !== want.audio) begin
            $display("%0t: audio_out mismatch, expected %0d, actual %0d",
                     $time, want.audio, audio);
            n_errors++;
         end
         if (be !== want.blk_end) begin
            $display("%0t: block_end_out mismatch, expected %0b, actual %0b",
                     $time, want.blk_end, be);
            n_errors++;
         end
      endfunction
   endclass

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic signed [SAMPLE_W-1:0] req_audio_in  = '0;
   logic                       req_block_end = 1'b0;
   logic                       rsp_stall     = 1'b0;
   logic                       csr_valid     = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index     = '0;
   logic [DELAY_W-1:0]         csr_wdata     = '0;
   logic                       req_stall;
   logic                       rsp_valid;
   logic signed [SAMPLE_W-1:0] rsp_audio_out;
   logic                       rsp_block_end_out;
   logic                       csr_ready;

   echo_scoreboard sb;
   int             n_settings  = 0;
   int             stall_run   = 0;
   int             quiet_count = 0;

   feedback_delay_line_interp_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_audio_in      (req_audio_in),
      .req_block_end     (req_block_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_audio_out     (rsp_audio_out),
      .rsp_block_end_out (rsp_block_end_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #10 clock = ~clock;

   // handshake monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index, csr_wdata);
         end
         if (req_valid && !req_stall) begin
            sb.note_sample(req_audio_in, req_block_end);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_mix(rsp_audio_out, rsp_block_end_out);
         end
      end
   end

   // output back-pressure: short stalls, a few long ones, and free runs
   always @(posedge clock) begin
      int r;
      if (stall_run > 0) begin
         stall_run--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            rsp_stall <= 1'b0;
            stall_run = $urandom_range(1, 12);
         end else if (r < 55) begin
            rsp_stall <= 1'b0;
            stall_run = $urandom_range(100, 300);
         end else if (r < 88) begin
            rsp_stall <= 1'b1;
            stall_run = $urandom_range(1, 3);
         end else begin
            rsp_stall <= 1'b1;
            stall_run = $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_count = 0;
      end else begin
         quiet_count++;
      end
      if (quiet_count >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles, %0d outputs outstanding",
                  $time, WATCHDOG_LIMIT, sb.mix_due.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0:       return 24'h7FFFFF;
         1:       return 24'h800000;
         2, 3:    return 24'($urandom_range(0, 2000) - 1000);
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [DELAY_W-1:0] pick_delay();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0:       return '0;
         1:       return 24'hFFFFFF;
         2:       return {16'hFFFF - 16'($urandom_range(0, 40)), 8'($urandom())};
         3:       return 24'($urandom());
         default: return 24'($urandom_range(1, 48 * 256));
      endcase
   endfunction

   // upper data bits ride along on gain writes and must be dropped
   function automatic logic [DELAY_W-1:0] pick_gain();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0:       return '0;
         1:       return {8'd0, ONE_Q15};
         2:       return {8'($urandom()), 16'($urandom_range(32769, 65535))};
         default: return {8'($urandom()), 16'($urandom_range(0, 32768))};
      endcase
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [DELAY_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_regs(input logic [DELAY_W-1:0] dly, input logic [DELAY_W-1:0] fb,
                               input logic [DELAY_W-1:0] wet);
      csr_write(CSR_DELAY, dly);
      csr_write(CSR_FEEDBACK, fb);
      csr_write(CSR_WET, wet);
      if ($urandom_range(0, 2) == 0) begin
         csr_write(CSR_SPARE, 24'($urandom()));
      end
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic be);
      req_valid     <= 1'b1;
      req_audio_in  <= s;
      req_block_end <= be;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // queue is read at the falling edge, after the monitor has logged the last beat
   task automatic wait_all_out(input int settle);
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.mix_due.size() != 0) @(negedge clock);
      @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   initial begin
      logic signed [SAMPLE_W-1:0] burst [13];
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // 1.5 sample delay, feedback gain above one, half wet: rails and rounding
      csr_write(CSR_SPARE, 24'hFFFFFF);
      program_regs(24'h000180, 24'h00FFFF, 24'h004000);
      burst = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                24'h800000, 24'h800000, 24'h800000, 24'h800000,
                24'h000000, 24'h000001, 24'hFFFFFF, 24'h555555, 24'hAAAAAA};
      foreach (burst[k]) begin
         send_sample(burst[k], k[0]);
         idle_gap(pick_gap());
      end
      wait_all_out(8);

      // zero delay, unity feedback, fully wet
      program_regs(24'h000000, {8'd0, ONE_Q15}, {8'd0, ONE_Q15});
      burst = '{24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF, 24'h000000, 24'h123456,
                24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
                24'h000000};
      for (int k = 0; k < 6; k++) begin
         send_sample(burst[k], (k == 5));
         idle_gap(pick_gap());
      end
      wait_all_out(8);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       program_regs(24'hFFFFFF, 24'h000000, 24'h000000);
            1:       program_regs(24'hFFFF00, {8'd0, ONE_Q15}, {8'd0, ONE_Q15});
            default: program_regs(pick_delay(), pick_gain(), pick_gain());
         endcase
         for (int k = 0; k < PHASE_BEATS; k++) begin
            send_sample(pick_sample(), ($urandom_range(0, 7) == 0));
            if (ph == 3 && k == PHASE_BEATS / 2) begin
               // hold input until the pipeline has emptied
               wait_all_out(0);
            end else begin
               idle_gap(pick_gap());
            end
         end
         wait_all_out(8);
      end

      wait_all_out(20);
      $display("Checked %0d output beats (%0d at the rails, %0d block-end marks)",
               sb.n_checked, sb.n_rail, sb.n_marks);
      $display("over %0d register settings; %0d mismatches", n_settings, sb.n_errors);
      if (sb.n_errors == 0 && sb.mix_due.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
